// ----- sv/egress_packet_filter_macros.svh -----
// assertion macros for the egress packet filter
`ifndef EGRESS_PACKET_FILTER_MACROS_SVH
`define EGRESS_PACKET_FILTER_MACROS_SVH

// property must hold at every clock edge outside reset
`define EPF_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// condition must never be seen outside reset
`define EPF_ASSERT_NEVER(name, clk, rstn, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ----- sv/epf_pkg.sv -----
// shared types, codes and constants of the egress packet filter
package epf_pkg;

  localparam int AddressEntriesDef = 512;
  localparam int SubnetEntriesDef  = 256;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_DNS_PORT    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DHCP_SERVER = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DHCP_CLIENT = 2'd2;

  localparam logic [15:0] DNS_PORT_RST    = 16'd53;
  localparam logic [15:0] DHCP_SERVER_RST = 16'd67;
  localparam logic [15:0] DHCP_CLIENT_RST = 16'd68;

  typedef enum logic [2:0] {
    OP_FRAME    = 3'd0,
    OP_ADDR_INS = 3'd1,
    OP_ADDR_REM = 3'd2,
    OP_NET_INS  = 3'd3,
    OP_NET_REM  = 3'd4
  } op_e;

  localparam logic [3:0] RSN_OK        = 4'd0;
  localparam logic [3:0] RSN_SHORT     = 4'd1;
  localparam logic [3:0] RSN_ETHERTYPE = 4'd2;
  localparam logic [3:0] RSN_VERSION   = 4'd3;
  localparam logic [3:0] RSN_OPTIONS   = 4'd4;
  localparam logic [3:0] RSN_FRAGMENT  = 4'd5;
  localparam logic [3:0] RSN_UDP_PORT  = 4'd6;
  localparam logic [3:0] RSN_DEST      = 4'd7;
  localparam logic [3:0] RSN_PROTOCOL  = 4'd8;

  localparam logic [1:0] TS_OK        = 2'd0;
  localparam logic [1:0] TS_FULL      = 2'd1;
  localparam logic [1:0] TS_NOT_FOUND = 2'd2;

  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  localparam logic [5:0]  POS_MAX     = 6'd63;
  localparam logic [5:0]  LEN_ETH     = 6'd14;
  localparam logic [5:0]  LEN_IPV4    = 6'd34;
  localparam logic [5:0]  LEN_UDP     = 6'd42;
  localparam logic [5:0]  LEN_TCP     = 6'd54;
  localparam logic [5:0]  PLEN_MAX    = 6'd32;
  localparam logic [15:0] ETH_ARP     = 16'h0806;
  localparam logic [15:0] ETH_IPV4    = 16'h0800;
  localparam logic [15:0] FRAG_MASK   = 16'h3FFF;
  localparam logic [3:0]  IP_VERSION  = 4'd4;
  localparam logic [3:0]  IP_IHL      = 4'd5;
  localparam logic [7:0]  PROTO_ICMP  = 8'd1;
  localparam logic [7:0]  PROTO_TCP   = 8'd6;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;

  typedef enum logic [2:0] {
    CMD_VERDICT,
    CMD_LOOKUP,
    CMD_ADDR_INS,
    CMD_ADDR_REM,
    CMD_NET_INS,
    CMD_NET_REM
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [3:0]  reason;
    logic [31:0] key;
    logic [5:0]  plen;
  } cmd_t;

  typedef struct packed {
    logic       kind;
    logic       allow;
    logic [3:0] reason;
    logic [1:0] status;
  } result_t;

  function automatic logic [31:0] prefix_mask(input logic [5:0] plen);
    logic [31:0] m;
    if (plen == 6'd0) begin
      m = '0;
    end else if (plen >= PLEN_MAX) begin
      m = '1;
    end else begin
      m = ~(32'hFFFF_FFFF >> plen);
    end
    return m;
  endfunction

endpackage

// ----- sv/epf_in_if.sv -----
// request channel into the filter
interface epf_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [7:0]  frame_byte;
  logic        frame_last;
  logic [31:0] entry_address;
  logic [5:0]  entry_prefix_length;

  modport source (output valid, operation, frame_byte, frame_last, entry_address,
                  entry_prefix_length, input ready);
  modport sink (input valid, operation, frame_byte, frame_last, entry_address,
                entry_prefix_length, output ready);
endinterface

// ----- sv/epf_out_if.sv -----
// result channel out of the filter
interface epf_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic       allow;
  logic [3:0] verdict_reason;
  logic [1:0] table_status;

  modport source (output valid, result_kind, allow, verdict_reason, table_status,
                  input ready);
  modport sink (input valid, result_kind, allow, verdict_reason, table_status,
                output ready);
endinterface

// ----- sv/egress_packet_filter.sv -----
// top level of the egress packet filter
//
//   channel  dir  handshake     carries
//   in_ch    in   valid/ready   frame byte or table request
//   out_ch   out  valid/ready   frame verdict or table acknowledge
//   cfg      in   cfg_we_i      port registers, no read-back
//
// a frame byte is taken while in_ch.ready is high; a verdict needing no table lookup
// passes through the request queue to the result register. a table request walks its
// store, a tcp/icmp verdict the address store and, on a miss, the subnet store, one entry a
// cycle, set by the single ram read ports. after reset both stores are cleared with
// in_ch.ready low; config writes are taken throughout.
// a two entry request queue lets bytes flow in while a walk or a stalled result is pending.
module egress_packet_filter #(
  parameter int ADDRESS_ENTRIES = epf_pkg::AddressEntriesDef,
  parameter int SUBNET_ENTRIES  = epf_pkg::SubnetEntriesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  epf_in_if.sink                       in_ch,
  epf_out_if.source                    out_ch,
  input  logic                         cfg_we_i,
  input  logic [epf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [epf_pkg::CfgDataW-1:0] cfg_data_i
);
  import epf_pkg::*;

  logic    init_done, q_full, q_push, q_valid, q_pop;
  cmd_t    push_cmd, head_cmd;
  result_t res;

  epf_front u_front (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_ch.valid),
    .in_ready_o           (in_ch.ready),
    .operation_i          (in_ch.operation),
    .frame_byte_i         (in_ch.frame_byte),
    .frame_last_i         (in_ch.frame_last),
    .entry_address_i      (in_ch.entry_address),
    .entry_prefix_length_i(in_ch.entry_prefix_length),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .init_done_i          (init_done),
    .q_full_i             (q_full),
    .q_push_o             (q_push),
    .q_cmd_o              (push_cmd)
  );

  epf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (push_cmd),
    .full_o (q_full),
    .valid_o(q_valid),
    .pop_i  (q_pop),
    .cmd_o  (head_cmd)
  );

  epf_back #(
    .ADDRESS_ENTRIES(ADDRESS_ENTRIES),
    .SUBNET_ENTRIES (SUBNET_ENTRIES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_cmd_i    (head_cmd),
    .q_pop_o    (q_pop),
    .init_done_o(init_done),
    .out_valid_o(out_ch.valid),
    .out_ready_i(out_ch.ready),
    .out_res_o  (res)
  );

  assign out_ch.result_kind    = res.kind;
  assign out_ch.allow          = res.allow;
  assign out_ch.verdict_reason = res.reason;
  assign out_ch.table_status   = res.status;
endmodule

// ----- sv/epf_ram.sv -----
// generic single write, single read ram with registered read
module epf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ----- sv/epf_front.sv -----
// frame parser, register file and command issue
module epf_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [2:0]                      operation_i,
  input  logic [7:0]                      frame_byte_i,
  input  logic                            frame_last_i,
  input  logic [31:0]                     entry_address_i,
  input  logic [5:0]                      entry_prefix_length_i,
  input  logic                            cfg_we_i,
  input  logic [epf_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [epf_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                            init_done_i,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output epf_pkg::cmd_t                   q_cmd_o
);
  import epf_pkg::*;

  logic [5:0]  pos_q, pos_d, n_len;
  logic [15:0] eth_q, eth_d, eth_c;
  logic [7:0]  vlen_q, vlen_d, vlen_c;
  logic [15:0] frag_q, frag_d, frag_c;
  logic [7:0]  proto_q, proto_d, proto_c;
  logic [31:0] daddr_q, daddr_d, daddr_c;
  logic [15:0] sport_q, sport_d, sport_c;
  logic [15:0] dport_q, dport_d, dport_c;
  logic [15:0] dns_q, dns_d, srv_q, srv_d, cli_q, cli_d;
  logic        accept, udp_ok, lookup;
  logic [3:0]  reason;
  logic [5:0]  plen_c;

  assign in_ready_o = init_done_i && !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    eth_c   = eth_q;
    vlen_c  = vlen_q;
    frag_c  = frag_q;
    proto_c = proto_q;
    daddr_c = daddr_q;
    sport_c = sport_q;
    dport_c = dport_q;
    priority if (pos_q == 6'd12 || pos_q == 6'd13) begin
      eth_c = {eth_q[7:0], frame_byte_i};
    end else if (pos_q == 6'd14) begin
      vlen_c = frame_byte_i;
    end else if (pos_q == 6'd20 || pos_q == 6'd21) begin
      frag_c = {frag_q[7:0], frame_byte_i};
    end else if (pos_q == 6'd23) begin
      proto_c = frame_byte_i;
    end else if (pos_q >= 6'd30 && pos_q <= 6'd33) begin
      daddr_c = {daddr_q[23:0], frame_byte_i};
    end else if (pos_q == 6'd34 || pos_q == 6'd35) begin
      sport_c = {sport_q[7:0], frame_byte_i};
    end else if (pos_q == 6'd36 || pos_q == 6'd37) begin
      dport_c = {dport_q[7:0], frame_byte_i};
    end
  end

  assign n_len  = (pos_q == POS_MAX) ? pos_q : pos_q + 6'd1;
  assign udp_ok = (sport_c == dns_q) || (dport_c == dns_q) ||
                  (dport_c == srv_q && sport_c == cli_q) ||
                  (dport_c == cli_q && sport_c == srv_q);

  always_comb begin
    lookup = 1'b0;
    reason = RSN_OK;
    priority if (n_len < LEN_ETH) begin
      reason = RSN_SHORT;
    end else if (eth_c == ETH_ARP) begin
      reason = RSN_OK;
    end else if (eth_c != ETH_IPV4) begin
      reason = RSN_ETHERTYPE;
    end else if (n_len < LEN_IPV4) begin
      reason = RSN_SHORT;
    end else if (vlen_c[7:4] != IP_VERSION) begin
      reason = RSN_VERSION;
    end else if (vlen_c[3:0] != IP_IHL) begin
      reason = RSN_OPTIONS;
    end else if ((frag_c & FRAG_MASK) != 16'd0) begin
      reason = RSN_FRAGMENT;
    end else if (proto_c == PROTO_UDP) begin
      reason = (n_len < LEN_UDP) ? RSN_SHORT : (udp_ok ? RSN_OK : RSN_UDP_PORT);
    end else if (proto_c == PROTO_TCP) begin
      reason = (n_len < LEN_TCP) ? RSN_SHORT : RSN_OK;
      lookup = (n_len >= LEN_TCP);
    end else if (proto_c == PROTO_ICMP) begin
      lookup = 1'b1;
    end else begin
      reason = RSN_PROTOCOL;
    end
  end

  assign plen_c = (entry_prefix_length_i > PLEN_MAX) ? PLEN_MAX : entry_prefix_length_i;

  always_comb begin
    pos_d    = pos_q;
    eth_d    = eth_q;
    vlen_d   = vlen_q;
    frag_d   = frag_q;
    proto_d  = proto_q;
    daddr_d  = daddr_q;
    sport_d  = sport_q;
    dport_d  = dport_q;
    q_push_o = 1'b0;
    q_cmd_o  = '{cmd: CMD_VERDICT, reason: reason, key: daddr_c, plen: plen_c};
    if (accept) begin
      unique case (operation_i)
        OP_FRAME: begin
          if (frame_last_i) begin
            pos_d    = '0;
            eth_d    = '0;
            vlen_d   = '0;
            frag_d   = '0;
            proto_d  = '0;
            daddr_d  = '0;
            sport_d  = '0;
            dport_d  = '0;
            q_push_o = 1'b1;
            q_cmd_o.cmd = lookup ? CMD_LOOKUP : CMD_VERDICT;
          end else begin
            pos_d   = n_len;
            eth_d   = eth_c;
            vlen_d  = vlen_c;
            frag_d  = frag_c;
            proto_d = proto_c;
            daddr_d = daddr_c;
            sport_d = sport_c;
            dport_d = dport_c;
          end
        end
        OP_ADDR_INS: begin
          q_push_o    = 1'b1;
          q_cmd_o.cmd = CMD_ADDR_INS;
          q_cmd_o.key = entry_address_i;
        end
        OP_ADDR_REM: begin
          q_push_o    = 1'b1;
          q_cmd_o.cmd = CMD_ADDR_REM;
          q_cmd_o.key = entry_address_i;
        end
        OP_NET_INS: begin
          q_push_o    = 1'b1;
          q_cmd_o.cmd = CMD_NET_INS;
          q_cmd_o.key = entry_address_i & prefix_mask(plen_c);
        end
        OP_NET_REM: begin
          q_push_o    = 1'b1;
          q_cmd_o.cmd = CMD_NET_REM;
          q_cmd_o.key = entry_address_i & prefix_mask(plen_c);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    dns_d = dns_q;
    srv_d = srv_q;
    cli_d = cli_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DNS_PORT:    dns_d = cfg_data_i;
        CFG_DHCP_SERVER: srv_d = cfg_data_i;
        CFG_DHCP_CLIENT: cli_d = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      eth_q   <= '0;
      vlen_q  <= '0;
      frag_q  <= '0;
      proto_q <= '0;
      daddr_q <= '0;
      sport_q <= '0;
      dport_q <= '0;
      dns_q   <= DNS_PORT_RST;
      srv_q   <= DHCP_SERVER_RST;
      cli_q   <= DHCP_CLIENT_RST;
    end else begin
      pos_q   <= pos_d;
      eth_q   <= eth_d;
      vlen_q  <= vlen_d;
      frag_q  <= frag_d;
      proto_q <= proto_d;
      daddr_q <= daddr_d;
      sport_q <= sport_d;
      dport_q <= dport_d;
      dns_q   <= dns_d;
      srv_q   <= srv_d;
      cli_q   <= cli_d;
    end
  end
endmodule

// ----- sv/epf_queue.sv -----
// two entry command queue between parser and table engine
module epf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  epf_pkg::cmd_t cmd_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output epf_pkg::cmd_t cmd_o
);
  import epf_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = entry_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end
endmodule

// ----- sv/epf_back.sv -----
// table engine: store walks, inserts, removes and result register
module epf_back #(
  parameter int ADDRESS_ENTRIES = epf_pkg::AddressEntriesDef,
  parameter int SUBNET_ENTRIES  = epf_pkg::SubnetEntriesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  epf_pkg::cmd_t   q_cmd_i,
  output logic            q_pop_o,
  output logic            init_done_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output epf_pkg::result_t out_res_o
);
  import epf_pkg::*;

  localparam int AW   = (ADDRESS_ENTRIES > 1) ? $clog2(ADDRESS_ENTRIES) : 1;
  localparam int SW   = (SUBNET_ENTRIES > 1) ? $clog2(SUBNET_ENTRIES) : 1;
  localparam int CW   = (AW > SW) ? AW : SW;
  localparam int MAXE = (ADDRESS_ENTRIES > SUBNET_ENTRIES) ? ADDRESS_ENTRIES : SUBNET_ENTRIES;
  localparam logic [CW-1:0] A_LAST = CW'(ADDRESS_ENTRIES - 1);
  localparam logic [CW-1:0] S_LAST = CW'(SUBNET_ENTRIES - 1);
  localparam logic [CW-1:0] C_LAST = CW'(MAXE - 1);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN} state_e;

  state_e    state_q, state_d;
  cmd_t      cmd_q, cmd_d;
  logic      net_q, net_d, fin_q, fin_d, rv_q, rv_d, ff_q, ff_d;
  logic [CW-1:0] cnt_q, cnt_d, ridx_q, ridx_d, fidx_q, fidx_d, cur_last, wr_idx;
  logic      out_valid_q, out_valid_d;
  result_t   res_q, res_d;
  logic      out_free, hit, is_free, wr_en, wr_set;

  logic          a_we, s_we;
  logic [AW-1:0] a_waddr;
  logic [SW-1:0] s_waddr;
  logic [32:0]   a_wdata, a_rdata;
  logic [38:0]   s_wdata, s_rdata;

  epf_ram #(.WIDTH(33), .DEPTH(ADDRESS_ENTRIES)) u_addr_ram (
    .clk_i  (clk_i),
    .we_i   (a_we),
    .waddr_i(a_waddr),
    .wdata_i(a_wdata),
    .raddr_i(cnt_q[AW-1:0]),
    .rdata_o(a_rdata)
  );

  epf_ram #(.WIDTH(39), .DEPTH(SUBNET_ENTRIES)) u_net_ram (
    .clk_i  (clk_i),
    .we_i   (s_we),
    .waddr_i(s_waddr),
    .wdata_i(s_wdata),
    .raddr_i(cnt_q[SW-1:0]),
    .rdata_o(s_rdata)
  );

  assign cur_last = net_q ? S_LAST : A_LAST;
  assign out_free = !out_valid_q || out_ready_i;
  assign is_free  = net_q ? !s_rdata[38] : !a_rdata[32];

  always_comb begin
    if (net_q) begin
      if (cmd_q.cmd == CMD_LOOKUP) begin
        hit = s_rdata[38] &&
              (((cmd_q.key ^ s_rdata[31:0]) & prefix_mask(s_rdata[37:32])) == 32'd0);
      end else begin
        hit = s_rdata[38] && (s_rdata[37:32] == cmd_q.plen) && (s_rdata[31:0] == cmd_q.key);
      end
    end else begin
      hit = a_rdata[32] && (a_rdata[31:0] == cmd_q.key);
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    net_d       = net_q;
    fin_d       = fin_q;
    rv_d        = rv_q;
    ff_d        = ff_q;
    cnt_d       = cnt_q;
    ridx_d      = ridx_q;
    fidx_d      = fidx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    res_d       = res_q;
    q_pop_o     = 1'b0;
    wr_en       = 1'b0;
    wr_set      = 1'b0;
    wr_idx      = ridx_q;
    unique case (state_q)
      S_CLEAR: begin
        if (cnt_q == C_LAST) begin
          state_d = S_IDLE;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          cmd_d   = q_cmd_i;
          cnt_d   = '0;
          fin_d   = 1'b0;
          rv_d    = 1'b0;
          ff_d    = 1'b0;
          net_d   = (q_cmd_i.cmd == CMD_NET_INS) || (q_cmd_i.cmd == CMD_NET_REM);
          if (q_cmd_i.cmd == CMD_VERDICT) begin
            out_valid_d = 1'b1;
            res_d = '{kind: KIND_VERDICT, allow: (q_cmd_i.reason == RSN_OK),
                      reason: q_cmd_i.reason, status: TS_OK};
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (!fin_q) begin
          rv_d   = 1'b1;
          ridx_d = cnt_q;
          if (cnt_q == cur_last) begin
            fin_d = 1'b1;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end else begin
          rv_d = 1'b0;
        end
        if (rv_q) begin
          res_d = '{kind: KIND_ACK, allow: 1'b0, reason: RSN_OK, status: TS_OK};
          if (hit) begin
            state_d     = S_IDLE;
            out_valid_d = 1'b1;
            if (cmd_q.cmd == CMD_LOOKUP) begin
              res_d = '{kind: KIND_VERDICT, allow: 1'b1, reason: RSN_OK, status: TS_OK};
            end else if (cmd_q.cmd == CMD_ADDR_REM || cmd_q.cmd == CMD_NET_REM) begin
              wr_en = 1'b1;
            end
          end else begin
            if (is_free && !ff_q) begin
              ff_d   = 1'b1;
              fidx_d = ridx_q;
            end
            if (ridx_q == cur_last) begin
              state_d     = S_IDLE;
              out_valid_d = 1'b1;
              unique case (cmd_q.cmd)
                CMD_LOOKUP: begin
                  if (!net_q) begin
                    state_d     = S_SCAN;
                    out_valid_d = out_valid_q && !out_ready_i;
                    net_d       = 1'b1;
                    cnt_d       = '0;
                    fin_d       = 1'b0;
                    rv_d        = 1'b0;
                  end else begin
                    res_d = '{kind: KIND_VERDICT, allow: 1'b0, reason: RSN_DEST,
                              status: TS_OK};
                  end
                end
                CMD_ADDR_INS, CMD_NET_INS: begin
                  if (ff_q || is_free) begin
                    wr_en  = 1'b1;
                    wr_set = 1'b1;
                    wr_idx = ff_q ? fidx_q : ridx_q;
                  end else begin
                    res_d.status = TS_FULL;
                  end
                end
                default: res_d.status = TS_NOT_FOUND;
              endcase
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (state_q == S_CLEAR) begin
      a_we    = ({1'b0, cnt_q} < (CW + 1)'(ADDRESS_ENTRIES));
      s_we    = ({1'b0, cnt_q} < (CW + 1)'(SUBNET_ENTRIES));
      a_waddr = cnt_q[AW-1:0];
      s_waddr = cnt_q[SW-1:0];
      a_wdata = '0;
      s_wdata = '0;
    end else begin
      a_we    = wr_en && !net_q;
      s_we    = wr_en && net_q;
      a_waddr = wr_idx[AW-1:0];
      s_waddr = wr_idx[SW-1:0];
      a_wdata = wr_set ? {1'b1, cmd_q.key} : 33'd0;
      s_wdata = wr_set ? {1'b1, cmd_q.plen, cmd_q.key} : 39'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      net_q       <= 1'b0;
      fin_q       <= 1'b0;
      rv_q        <= 1'b0;
      ff_q        <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      net_q       <= net_d;
      fin_q       <= fin_d;
      rv_q        <= rv_d;
      ff_q        <= ff_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    ridx_q <= ridx_d;
    fidx_q <= fidx_d;
    res_q  <= res_d;
  end

  assign init_done_o = (state_q != S_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;
endmodule

// ----- sv/epf_checker.sv -----
// port level checks of the egress packet filter and their binding
`include "egress_packet_filter_macros.svh"

module epf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid,
  input logic       out_ready,
  input logic       result_kind,
  input logic       allow,
  input logic [3:0] verdict_reason,
  input logic [1:0] table_status
);
  import epf_pkg::*;

  `EPF_ASSERT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `EPF_ASSERT_NEVER(a_ack_clean, clk_i, rst_ni, out_valid && result_kind == KIND_ACK && (allow || verdict_reason != RSN_OK), "acknowledge carries verdict bits")
  `EPF_ASSERT_NEVER(a_verdict_status, clk_i, rst_ni, out_valid && result_kind == KIND_VERDICT && table_status != TS_OK, "verdict carries table status")
  `EPF_ASSERT_NEVER(a_allow_reason, clk_i, rst_ni, out_valid && result_kind == KIND_VERDICT && (allow != (verdict_reason == RSN_OK)), "allow disagrees with reason")
endmodule

bind egress_packet_filter epf_checker u_epf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .result_kind   (out_ch.result_kind),
  .allow         (out_ch.allow),
  .verdict_reason(out_ch.verdict_reason),
  .table_status  (out_ch.table_status)
);
